// ===== design/mssr_pkg.sv =====
package mssr_pkg;

  localparam int FULL_SCALE = 1023;

  localparam int DUTY_W = 10;
  localparam int REQ_W  = 11;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_CODE_W = 2;

  // largest duty the duty fields and the full scale both allow
  localparam logic [DUTY_W-1:0] DUTY_MAX =
    DUTY_W'((FULL_SCALE < 1023) ? FULL_SCALE : 1023);

  localparam logic [DUTY_W-1:0] DEADBAND_RST  = 10'd0;
  localparam logic [DUTY_W-1:0] RAMP_STEP_RST = 10'd64;
  localparam logic [DUTY_W-1:0] LOCK_RST      = 10'd80;

  typedef logic [DUTY_W-1:0] duty_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_STOP   = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND  = 2'd0,
    CFG_RAMP_STEP = 2'd1,
    CFG_LOCK      = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_STOPPED = 3'b001,
    MODE_RAMP    = 3'b010,
    MODE_RUN     = 3'b100
  } mode_t;

  localparam logic [MODE_CODE_W-1:0] CODE_STOPPED = 2'd0;
  localparam logic [MODE_CODE_W-1:0] CODE_RAMP    = 2'd1;
  localparam logic [MODE_CODE_W-1:0] CODE_RUN     = 2'd2;

  typedef struct packed {
    duty_t deadband;
    duty_t ramp_step;
    duty_t lock_level;
  } cfg_t;

  typedef struct packed {
    duty_t                  forward_duty;
    duty_t                  reverse_duty;
    logic [MODE_CODE_W-1:0] drive_mode;
    logic                   request_refused;
  } result_t;

endpackage

// ===== design/mssr_in_if.sv =====
interface mssr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           opcode;
  logic signed [mssr_pkg::REQ_W-1:0]    duty_request;

  modport source (output valid, output opcode, output duty_request, input ready);
  modport sink (input valid, input opcode, input duty_request, output ready);
endinterface

// ===== design/mssr_out_if.sv =====
interface mssr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mssr_pkg::DUTY_W-1:0]          forward_duty;
  logic [mssr_pkg::DUTY_W-1:0]          reverse_duty;
  logic [mssr_pkg::MODE_CODE_W-1:0]     drive_mode;
  logic                                 request_refused;

  modport source (output valid, output forward_duty, output reverse_duty,
                  output drive_mode, output request_refused, input ready);
  modport sink (input valid, input forward_duty, input reverse_duty,
                input drive_mode, input request_refused, output ready);
endinterface

// ===== design/mssr_cfg_if.sv =====
interface mssr_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [mssr_pkg::CFG_IDX_W-1:0]       index;
  logic [mssr_pkg::DUTY_W-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/mssr_cfg_regs.sv =====
module mssr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [mssr_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [mssr_pkg::DUTY_W-1:0]      wr_data,
  output mssr_pkg::cfg_t                   cfg
);
  import mssr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_DEADBAND:  cfg_nxt.deadband   = wr_data;
        CFG_RAMP_STEP: cfg_nxt.ramp_step  = wr_data;
        CFG_LOCK:      cfg_nxt.lock_level = wr_data;
        default:       cfg_nxt = cfg_r;  // drop writes past the last register
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband   <= DEADBAND_RST;
      cfg_r.ramp_step  <= RAMP_STEP_RST;
      cfg_r.lock_level <= LOCK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/mssr_ctrl.sv =====
module mssr_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step_en,
  input  logic [1:0]                          opcode,
  input  logic signed [mssr_pkg::REQ_W-1:0]   duty_request,
  input  mssr_pkg::cfg_t                      cfg,
  output mssr_pkg::result_t                   result
);
  import mssr_pkg::*;

  mode_t mode_r, mode_nxt;
  duty_t cur_r, cur_nxt;
  duty_t target_r, target_nxt;
  logic  dir_fwd_r, dir_fwd_nxt;
  duty_t pin_fwd_r, pin_fwd_nxt;
  duty_t pin_rev_r, pin_rev_nxt;
  logic  refused;

  duty_t             step;
  logic [DUTY_W:0]   ramp_sum;
  logic              req_fwd;
  logic [REQ_W-1:0]  mag_raw;
  duty_t             mag;
  logic              drive;

  assign step     = (cfg.ramp_step == '0) ? DUTY_W'(1) : cfg.ramp_step;
  assign ramp_sum = {1'b0, cur_r} + {1'b0, step};
  assign req_fwd  = !duty_request[REQ_W-1];
  assign mag_raw  = req_fwd ? REQ_W'(duty_request) : REQ_W'(-duty_request);
  assign mag      = (mag_raw > {1'b0, DUTY_MAX}) ? DUTY_MAX : mag_raw[DUTY_W-1:0];

  always_comb begin
    mode_nxt    = mode_r;
    cur_nxt     = cur_r;
    target_nxt  = target_r;
    dir_fwd_nxt = dir_fwd_r;
    refused     = 1'b0;
    drive       = 1'b0;
    case (opcode_t'(opcode))
      OP_TICK: begin
        drive = 1'b1;
        if (target_r < cfg.deadband) begin
          cur_nxt  = '0;
          mode_nxt = MODE_STOPPED;
        end else begin
          case (mode_r)
            MODE_STOPPED: begin
              mode_nxt = MODE_RAMP;
              cur_nxt  = '0;
            end
            MODE_RAMP: begin
              if (ramp_sum >= {1'b0, target_r}) begin
                cur_nxt  = target_r;
                mode_nxt = MODE_RUN;
              end else begin
                cur_nxt = ramp_sum[DUTY_W-1:0];
              end
            end
            default: cur_nxt = target_r;
          endcase
        end
      end
      OP_SET: begin
        if (req_fwd != dir_fwd_r && cur_r > cfg.lock_level) begin
          refused = 1'b1;
        end else begin
          dir_fwd_nxt = req_fwd;
          target_nxt  = mag;
          if (mag < cfg.deadband) begin
            mode_nxt = MODE_STOPPED;
          end else if (mode_r == MODE_STOPPED) begin
            mode_nxt = MODE_RAMP;
          end
        end
      end
      OP_STOP: begin
        drive      = 1'b1;
        target_nxt = '0;
        cur_nxt    = '0;
        mode_nxt   = MODE_STOPPED;
      end
      default: refused = 1'b0;
    endcase
  end

  // pins follow the updated state on tick and stop only
  always_comb begin
    pin_fwd_nxt = pin_fwd_r;
    pin_rev_nxt = pin_rev_r;
    if (drive) begin
      if (mode_nxt == MODE_STOPPED) begin
        pin_fwd_nxt = '0;
        pin_rev_nxt = '0;
      end else if (dir_fwd_nxt) begin
        pin_fwd_nxt = cur_nxt;
        pin_rev_nxt = '0;
      end else begin
        pin_fwd_nxt = '0;
        pin_rev_nxt = cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_STOPPED;
      cur_r     <= '0;
      target_r  <= '0;
      dir_fwd_r <= 1'b1;
      pin_fwd_r <= '0;
      pin_rev_r <= '0;
    end else if (step_en) begin
      mode_r    <= mode_nxt;
      cur_r     <= cur_nxt;
      target_r  <= target_nxt;
      dir_fwd_r <= dir_fwd_nxt;
      pin_fwd_r <= pin_fwd_nxt;
      pin_rev_r <= pin_rev_nxt;
    end
  end

  always_comb begin
    result.forward_duty    = pin_fwd_nxt;
    result.reverse_duty    = pin_rev_nxt;
    result.request_refused = refused;
    case (mode_nxt)
      MODE_RAMP: result.drive_mode = CODE_RAMP;
      MODE_RUN:  result.drive_mode = CODE_RUN;
      default:   result.drive_mode = CODE_STOPPED;
    endcase
  end

  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    pin_fwd_r == '0 || pin_rev_r == '0)
    else $error("both bridge pins driven");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && opcode == OP_STOP |=> cur_r == '0 && target_r == '0 && mode_r == MODE_STOPPED)
    else $error("hard stop left state behind");

  a_refuse_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && refused |=> $stable(target_r) && $stable(dir_fwd_r) && $stable(mode_r))
    else $error("refused request changed state");

  a_refuse_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    refused |-> opcode == OP_SET)
    else $error("refusal on a non set-duty word");

endmodule

// ===== design/motor_soft_start_ramp_core.sv =====
// channel  dir  carries                                         handshake
// in_s     in   opcode, duty_request                            valid/ready
// out_s    out  forward_duty, reverse_duty, drive_mode, refused valid/ready
// cfg_s    in   index, data (deadband, ramp_step, lock level)   valid/ready, ready always 1
//
// One word per cycle sustained while out_s.ready stays high; an accepted word goes into
// the input register, then through the state update and into the result register.
// Synchronous active-low reset: mode stopped, duties zero, direction forward,
// registers at 0 / 64 / 80, both channel registers empty.
// A stalled result holds the input register; in_s.ready drops only when both
// stages are full and the result is not taken.
module motor_soft_start_ramp_core (
  input  logic clk,
  input  logic rst_n,
  mssr_in_if.sink    in_s,
  mssr_out_if.source out_s,
  mssr_cfg_if.sink   cfg_s
);
  import mssr_pkg::*;

  logic                     in_valid_r;
  logic [1:0]               opcode_r;
  logic signed [REQ_W-1:0]  duty_req_r;
  logic                     out_valid_r;
  result_t                  out_r;
  result_t                  result;
  cfg_t                     cfg;
  logic                     advance;
  logic                     in_take;

  assign advance  = in_valid_r && (!out_valid_r || out_s.ready);
  assign in_take  = in_s.valid && in_s.ready;
  assign in_s.ready  = !in_valid_r || advance;
  assign cfg_s.ready = 1'b1;

  mssr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_s.valid),
    .wr_index (cfg_s.index),
    .wr_data  (cfg_s.data),
    .cfg      (cfg)
  );

  mssr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .opcode       (opcode_r),
    .duty_request (duty_req_r),
    .cfg          (cfg),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      opcode_r   <= in_s.opcode;
      duty_req_r <= in_s.duty_request;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_s.valid           = out_valid_r;
  assign out_s.forward_duty    = out_r.forward_duty;
  assign out_s.reverse_duty    = out_r.reverse_duty;
  assign out_s.drive_mode      = out_r.drive_mode;
  assign out_s.request_refused = out_r.request_refused;

  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(opcode_r) && $stable(duty_req_r))
    else $error("pending word lost");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_s.ready |-> !in_s.ready)
    else $error("word taken with both stages full");

endmodule
